>>> rtl/core/signed_int_to_decimal_ascii_core_macros.svh
// Assertion macros for the signed integer to decimal ASCII core.
// Needs clk and arst_n in the scope of each use; define NO_ASSERTIONS to drop them.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SIDAC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SIDAC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SIDAC_ASSERT_IMP(lbl, ante, cons, msg)
`define SIDAC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/sidac_pkg.sv
// Shared constants, types and helpers for the signed integer to decimal ASCII core.
// No dependencies.
package sidac_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// Decimal digits needed for the largest magnitude, 2^(width-1)
	function automatic int num_digits(input int width);
		return ((width - 1) * 30103) / 100000 + 1;
	endfunction

	// Status of the BCD conversion unit
	typedef struct packed {
		logic busy;
		logic done;
	} dab_stat_t;

endpackage

>>> rtl/core/signed_int_to_decimal_ascii_core.sv
// Converts a signed integer to decimal ASCII text, one character per strobe.
// An item is taken when start is high and busy is low. The magnitude goes
// through the BCD converter at one bit per cycle, then a pickup step takes
// the digit count; then the characters come out one per cycle, '-' first for
// negative values (registered in the pickup step, so the sign costs no extra
// time), most significant digit next, last high on the final digit. Busy stays
// high from the accept until the final character is registered. The final
// character is on the ports in the first cycle with busy low, and a new item
// can be accepted as early as that cycle. Each character is on the ports for
// exactly one cycle and the receiver cannot stall it.
// Depends on sidac_pkg, sidac_dabble and signed_int_to_decimal_ascii_core_macros.svh.
`include "signed_int_to_decimal_ascii_core_macros.svh"

module signed_int_to_decimal_ascii_core #(
	parameter int VALUE_WIDTH = sidac_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          busy,
	output logic                          strobe,
	output logic [7:0]                    character,
	output logic                          last
);

	localparam int NDIG = sidac_pkg::num_digits(VALUE_WIDTH);
	localparam int LENW = $clog2(NDIG + 1);
	localparam int IDXW = $clog2(NDIG);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic                    neg_q;
	logic [IDXW-1:0]         idx_q;
	logic                    strobe_q;
	logic [7:0]              char_q;
	logic                    last_q;
	logic                    load;
	logic [VALUE_WIDTH-1:0]  mag;
	sidac_pkg::dab_stat_t    dab_stat;
	logic [NDIG-1:0][3:0]    digits;
	logic [LENW-1:0]         len;

	assign busy = (state_q != ST_IDLE);
	assign load = start && !busy;

	// unsigned magnitude; the most negative value maps to 2^(VALUE_WIDTH-1)
	assign mag = value[VALUE_WIDTH-1] ? (~$unsigned(value) + VALUE_WIDTH'(1))
		: $unsigned(value);

	sidac_dabble #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dabble (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (load),
		.mag   (mag),
		.stat  (dab_stat),
		.digits(digits),
		.len   (len)
	);

	// sequencer and registered character outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			neg_q    <= 1'b0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
			char_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (load) begin
						neg_q   <= value[VALUE_WIDTH-1];
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (dab_stat.done) begin
						idx_q <= IDXW'(len - LENW'(1));
						// sign goes out while the first digit is selected
						if (neg_q) begin
							strobe_q <= 1'b1;
							char_q   <= sidac_pkg::CHAR_MINUS;
							last_q   <= 1'b0;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					char_q   <= sidac_pkg::CHAR_ZERO + {4'd0, digits[idx_q]};
					last_q   <= (idx_q == '0);
					if (idx_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q - IDXW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

	`SIDAC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
	`SIDAC_ASSERT_NXT(a_last_ends, strobe && last, !strobe, "character after last")
	`SIDAC_ASSERT_IMP(a_conv_unit_busy, state_q == ST_CONV && !dab_stat.done, dab_stat.busy,
		"waiting on idle converter")

endmodule

>>> rtl/core/sidac_dabble.sv
// Iterative binary to BCD converter (shift and add-3), one magnitude bit per cycle.
// Depends on sidac_pkg and signed_int_to_decimal_ascii_core_macros.svh.
`include "signed_int_to_decimal_ascii_core_macros.svh"

module sidac_dabble #(
	parameter int VALUE_WIDTH = sidac_pkg::VALUE_WIDTH_DEF,
	localparam int NDIG = sidac_pkg::num_digits(VALUE_WIDTH),
	localparam int LENW = $clog2(NDIG + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic [VALUE_WIDTH-1:0]   mag,
	output sidac_pkg::dab_stat_t     stat,
	output logic [NDIG-1:0][3:0]     digits,
	output logic [LENW-1:0]          len
);

	localparam int IDXW = $clog2(NDIG);
	localparam int CNTW = $clog2(VALUE_WIDTH + 1);
	localparam int BCDW = 4 * NDIG;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [NDIG-1:0][3:0]   bcd_q;
	logic [NDIG-1:0][3:0]   adj;
	logic [NDIG-1:0][3:0]   nxt;
	logic [LENW-1:0]        len_q;
	logic [CNTW-1:0]        cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic                   grow;

	// add-3 on every digit of 5 or more, then shift in the next magnitude bit
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		nxt = BCDW'({adj, mag_q[VALUE_WIDTH-1]});
		// doubling adds at most one significant digit per step
		grow = (len_q < LENW'(NDIG)) && (nxt[len_q[IDXW-1:0]] != 4'd0);
	end

	// control: bit counter, significant digit count, status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			len_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(VALUE_WIDTH);
				len_q  <= LENW'(1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (grow) begin
					len_q <= len_q + LENW'(1);
				end
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: magnitude shifter and BCD accumulator
	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			mag_q <= mag_q << 1;
			bcd_q <= nxt;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign digits    = bcd_q;
	assign len       = len_q;

	`SIDAC_ASSERT_IMP(a_len_bound, busy_q, len_q <= LENW'(NDIG), "digit count overran")
	`SIDAC_ASSERT_NXT(a_done_after_last_bit, busy_q && cnt_q == CNTW'(1) && !load, done_q,
		"no done after final bit")
	`SIDAC_ASSERT_NXT(a_done_pulse, done_q, !done_q, "done held longer than one cycle")

endmodule

>>> bench/signed_int_to_decimal_ascii_core_tb.sv
// Self-checking bench for signed_int_to_decimal_ascii_core: corner and random values,
// with every character checked against a built-in decimal text predictor.
// Depends on sidac_pkg and the core RTL.
module signed_int_to_decimal_ascii_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W            = sidac_pkg::VALUE_WIDTH_DEF;
	localparam int RANDOM_ITEMS = 328;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	// Values with a known weak spot: digit count edges, sign edges, range ends
	localparam logic signed [31:0] CORNER_VALUES [22] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
		32'sd100, -32'sd100, 32'sd999999999, 32'sd1000000000, -32'sd1000000000,
		32'sh7FFFFFFF, -32'sd2147483647, 32'sh80000000, 32'sd1234567890,
		-32'sd1234567890, 32'sh55555555, 32'shAAAAAAAA, 32'sd12345, -32'sd987654
	};

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start  = 1'b0;
	logic signed [W-1:0]  value  = '0;
	logic                 busy;
	logic                 strobe;
	logic [7:0]           character;
	logic                 last;

	logic signed [W-1:0]  pending_values[$];
	text_char_t           expected_text[$];
	int                   total_items;
	int                   accepted_items = 0;
	int                   negative_items = 0;
	int                   checked_chars  = 0;
	int                   errors         = 0;
	int                   gap_left       = 0;
	int                   cycle_count    = 0;

	signed_int_to_decimal_ascii_core #(.VALUE_WIDTH(W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Decimal text of one value: optional minus, then digits, last on the final one
	function automatic void queue_decimal_text(input logic signed [W-1:0] v);
		logic [W-1:0] mag;
		logic [7:0]   digs [0:31];
		int           n;
		text_char_t   c;
		n = 0;
		mag = v[W-1] ? (~v + 1'b1) : v;
		do begin
			digs[n] = sidac_pkg::CHAR_ZERO + 8'(mag % 10);
			mag = mag / 10;
			n++;
		end while (mag != 0);
		if (v[W-1]) begin
			c.code = sidac_pkg::CHAR_MINUS;
			c.last = 1'b0;
			expected_text.push_back(c);
		end
		for (int i = n - 1; i >= 0; i--) begin
			c.code = digs[i];
			c.last = (i == 0);
			expected_text.push_back(c);
		end
	endfunction

	// Random value with a spread of digit counts and both signs
	function automatic logic signed [W-1:0] random_value();
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1, 2: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					v = ~v + 1'b1;
			end
			default: v = 32'($urandom_range(0, 40)) - 32'd20;
		endcase
		return v;
	endfunction

	// Driver: sender idles 27% then 71% then never, in thirds of the run
	always @(posedge clk) begin
		int idle_pct;
		if (accepted_items < total_items / 3)
			idle_pct = 27;
		else if (accepted_items < (2 * total_items) / 3)
			idle_pct = 71;
		else
			idle_pct = 0;
		if (arst_n) begin
			if (start && !busy) begin
				queue_decimal_text(value);
				if (value[W-1])
					negative_items++;
				accepted_items++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
					value <= random_value();
				end else if (pending_values.size() > 0 && $urandom_range(0, 99) < idle_pct) begin
					gap_left = $urandom_range(0, 47);
					start <= 1'b0;
					value <= random_value();
				end else if (pending_values.size() > 0) begin
					start <= 1'b1;
					value <= pending_values.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed character against the oldest expected one
	always @(posedge clk) begin : text_check
		text_char_t want;
		if (arst_n && strobe) begin
			checked_chars++;
			if (expected_text.size() == 0) begin
				errors++;
				$display("%0t: unexpected character: expected none, actual %02h last %0b",
					$time, character, last);
			end else begin
				want = expected_text.pop_front();
				if (character !== want.code) begin
					errors++;
					$display("%0t: character mismatch: expected %02h, actual %02h",
						$time, want.code, character);
				end
				if (last !== want.last) begin
					errors++;
					$display("%0t: last mismatch: expected %0b, actual %0b",
						$time, want.last, last);
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL signed_int_to_decimal_ascii_core");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		foreach (CORNER_VALUES[i])
			pending_values.push_back(W'(CORNER_VALUES[i]));
		for (int i = 0; i < RANDOM_ITEMS; i++)
			pending_values.push_back(random_value());
		total_items = pending_values.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_values.size() > 0 || start)
			@(posedge clk);
		while (expected_text.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d values (%0d negative), %0d characters checked.",
			accepted_items, negative_items, checked_chars);
		$display("Covered zero, both range ends, digit count edges and random magnitudes.");
		if (errors == 0)
			$display("PASS signed_int_to_decimal_ascii_core");
		else
			$display("FAIL signed_int_to_decimal_ascii_core");
		$finish;
	end

endmodule
